// ===== src/suvf_pkg.sv =====
// ----------------------------------------------------------------------------
// suvf_pkg: shared types and constants for the sensor unwrap velocity filter
// Register indexes, reset values, fixed-point scale factors and the widths of
// the shared multiplier used by the core.
// ----------------------------------------------------------------------------
package suvf_pkg;

	// Default sizes for the core's parameters.
	localparam int DEF_SAMPLE_BITS     = 10;
	localparam int DEF_FLIP_COUNT_BITS = 7;

	// Configuration port.
	localparam int CFG_DATA_W = 15;

	typedef enum logic [1:0] {
		REG_FLIP_THRESHOLD  = 2'd0,
		REG_STEP_LIMIT_MRAD = 2'd1,
		REG_COEF_CURRENT    = 2'd2,
		REG_COEF_FEEDBACK   = 2'd3
	} cfg_reg_t;

	localparam logic [9:0]  RST_FLIP_THRESHOLD  = 10'd900;
	localparam logic [9:0]  RST_STEP_LIMIT_MRAD = 10'd10;
	localparam logic [14:0] RST_COEF_CURRENT    = 15'd14415;
	localparam logic [14:0] RST_COEF_FEEDBACK   = 15'd3939;

	// Output field widths.
	localparam int COUNT_W = 17;
	localparam int ANGLE_W = 22;
	localparam int VEL_W   = 14;

	// Internal widths.
	localparam int TH_W    = 24;   // absolute angle, Q16 rad
	localparam int ABS_W   = 23;   // magnitude of one angle step, Q16 rad
	localparam int STEP_W  = 11;   // accepted step, mrad
	localparam int VRAW_W  = 20;   // unfiltered velocity, Q8 rad/s
	localparam int VSUM_W  = 21;

	// Shared multiplier: signed MUL_A_W x signed MUL_B_W.
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 22;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Fixed-point scale factors.
	localparam int RAD_PER_COUNT_Q32 = 1091654;
	localparam int ANGLE_OFFSET_Q16  = 8391;
	localparam int MRAD_PER_RAD      = 1000;
	localparam int VEL_Q8_PER_MRAD   = 640;

endpackage

// ===== src/sensor_unwrap_velocity_filter_core.sv =====
// ----------------------------------------------------------------------------
// sensor_unwrap_velocity_filter_core: angle unwrap with smoothed velocity
// Unwraps a wrapping position sensor, converts the count to a relative angle
// and derives a rate-limited, first-order filtered angular velocity.
// ----------------------------------------------------------------------------
// A sample's result is loaded into the output register when the sequencer leaves
// its last step, and the next sample is only accepted back in idle, so the block
// takes no new sample before the last one is through. The twelve sequencer
// steps work around a single 24 x 22 bit signed multiplier with a registered
// product. The multiplier is used six times per sample: flip correction, count
// to angle, step to milliradians, step to velocity and the two filter terms.
// The input is ready again once the result is loaded. A result may wait in the
// output register while the next sample is taken. The sequencer stalls only if
// a second result is finished before the first has been taken. The first
// sample after reset defines angle zero. Configuration writes are taken in
// every cycle and must only be issued while no sample is in flight.
module sensor_unwrap_velocity_filter_core
	import suvf_pkg::*;
#(
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
	parameter int FLIP_COUNT_BITS = DEF_FLIP_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [SAMPLE_BITS-1:0]      raw_pos,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [COUNT_W-1:0]   position_count,
	output logic signed [ANGLE_W-1:0]   angle,
	output logic signed [VEL_W-1:0]     velocity,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  cfg_reg_t                    cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_CNT, S_SUM, S_TH, S_DQ, S_MAG, S_MRAD,
		S_STEP, S_VR, S_SUMV, S_ACC1, S_ACC2, S_FILT
	} state_t;

	localparam logic signed [FLIP_COUNT_BITS-1:0] FLIP_MAX =
		{1'b0, {(FLIP_COUNT_BITS-1){1'b1}}};
	localparam logic signed [FLIP_COUNT_BITS-1:0] FLIP_MIN =
		{1'b1, {(FLIP_COUNT_BITS-1){1'b0}}};

	function automatic logic signed [COUNT_W-1:0] sat_count(
		input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'((1 << (COUNT_W - 1)) - 1);
		lo = -hi - PROD_W'(1);
		if (v > hi) return hi[COUNT_W-1:0];
		else if (v < lo) return lo[COUNT_W-1:0];
		else return v[COUNT_W-1:0];
	endfunction

	function automatic logic signed [ANGLE_W-1:0] sat_angle(
		input logic signed [TH_W-1:0] v);
		logic signed [TH_W-1:0] hi;
		logic signed [TH_W-1:0] lo;
		hi = TH_W'((1 << (ANGLE_W - 1)) - 1);
		lo = -hi - TH_W'(1);
		if (v > hi) return hi[ANGLE_W-1:0];
		else if (v < lo) return lo[ANGLE_W-1:0];
		else return v[ANGLE_W-1:0];
	endfunction

	function automatic logic signed [VRAW_W-1:0] sat_vraw(
		input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'((1 << (VRAW_W - 1)) - 1);
		lo = -hi - PROD_W'(1);
		if (v > hi) return hi[VRAW_W-1:0];
		else if (v < lo) return lo[VRAW_W-1:0];
		else return v[VRAW_W-1:0];
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_vel(
		input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'((1 << (VEL_W - 1)) - 1);
		lo = -hi - PROD_W'(1);
		if (v > hi) return hi[VEL_W-1:0];
		else if (v < lo) return lo[VEL_W-1:0];
		else return v[VEL_W-1:0];
	endfunction

	state_t state_q;

	// Configuration registers.
	logic [9:0]  flip_threshold_q;
	logic [9:0]  step_limit_mrad_q;
	logic [14:0] coef_current_q;
	logic [14:0] coef_feedback_q;

	// Per-sample history.
	logic [SAMPLE_BITS-1:0]            last_sample_q;
	logic [SAMPLE_BITS-1:0]            older_sample_q;
	logic [SAMPLE_BITS-1:0]            held_offset_q;
	logic signed [FLIP_COUNT_BITS-1:0] flip_count_q;
	logic                              just_flipped_q;
	logic                              bias_pending_q;
	logic signed [ANGLE_W-1:0]         angle_bias_q;
	logic signed [TH_W-1:0]            th_prev_q;
	logic signed [STEP_W-1:0]          held_step_q;
	logic signed [VRAW_W-1:0]          prev_raw_vel_q;
	logic signed [VEL_W-1:0]           prev_filt_vel_q;

	// Working registers of the sequencer.
	logic [SAMPLE_BITS-1:0]    raw_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [COUNT_W-1:0] count_q;
	logic signed [TH_W-1:0]    th_now_q;
	logic [ABS_W-1:0]          abs_dq_q;
	logic                      dq_neg_q;
	logic signed [ANGLE_W-1:0] ang_q;
	logic signed [VRAW_W-1:0]  vraw_q;
	logic signed [VSUM_W-1:0]  vsum_q;

	// Output registers.
	logic                      out_valid_q;
	logic signed [COUNT_W-1:0] position_count_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [VEL_W-1:0]   velocity_q;

	// Shared multiplier operands.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	// Combinational terms.
	logic                      in_take;
	logic [SAMPLE_BITS:0]      diff1;
	logic [SAMPLE_BITS:0]      diff2;
	logic [SAMPLE_BITS-1:0]    off1;
	logic [SAMPLE_BITS-1:0]    off2;
	logic                      wrap_hit;
	logic signed [PROD_W-1:0]  cnt_sum;
	logic signed [PROD_W-1:0]  th_round;
	logic signed [TH_W-1:0]    th_calc;
	logic signed [TH_W-1:0]    dq;
	logic signed [TH_W-1:0]    bias_sel;
	logic signed [TH_W-1:0]    ang_diff;
	logic [PROD_W-17:0]        dmag;
	logic                      step_over;
	logic signed [STEP_W-1:0]  mrad;
	logic signed [VRAW_W-1:0]  vraw_calc;
	logic signed [PROD_W-1:0]  filt_sum;
	logic signed [PROD_W-1:0]  filt_shift;
	logic signed [VEL_W-1:0]   vf_calc;
	logic                      out_free;

	assign in_ready       = (state_q == S_IDLE);
	assign in_take        = in_valid && in_ready;
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign position_count = position_count_q;
	assign angle          = angle_q;
	assign velocity       = velocity_q;
	assign out_free       = !out_valid_q || out_ready;

	// Wrap detection compares against the sample two ticks back; a wrap is
	// never declared on two consecutive ticks.
	always_comb begin
		diff1    = {1'b0, raw_pos} - {1'b0, last_sample_q};
		diff2    = {1'b0, raw_pos} - {1'b0, older_sample_q};
		off1     = diff1[SAMPLE_BITS] ? SAMPLE_BITS'(-diff1) : diff1[SAMPLE_BITS-1:0];
		off2     = diff2[SAMPLE_BITS] ? SAMPLE_BITS'(-diff2) : diff2[SAMPLE_BITS-1:0];
		wrap_hit = (32'(off2) > 32'(flip_threshold_q)) && !just_flipped_q;
	end

	always_comb begin
		cnt_sum    = prod_q + $signed(PROD_W'(raw_q));
		th_round   = (prod_q + PROD_W'(32768)) >>> 16;
		th_calc    = TH_W'(ANGLE_OFFSET_Q16) - th_round[TH_W-1:0];
		dq         = th_now_q - th_prev_q;
		bias_sel   = bias_pending_q ? th_now_q : TH_W'(angle_bias_q);
		ang_diff   = th_now_q - bias_sel;
		dmag       = prod_q[PROD_W-1:16];
		step_over  = dmag > (PROD_W-16)'(step_limit_mrad_q);
		mrad       = dq_neg_q ? -$signed(dmag[STEP_W-1:0]) : $signed(dmag[STEP_W-1:0]);
		vraw_calc  = sat_vraw(prod_q);
		filt_sum   = acc_q + prod_q + PROD_W'(16384);
		filt_shift = filt_sum >>> 15;
		vf_calc    = sat_vel(filt_shift);
	end

	// Operand selection for the shared multiplier. The feedback operands stay
	// selected while the finished result waits, so the product is kept.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q) inside
			S_CNT: begin
				mul_a = MUL_A_W'(flip_count_q);
				mul_b = MUL_B_W'(held_offset_q);
			end
			S_TH: begin
				mul_a = MUL_A_W'(count_q);
				mul_b = MUL_B_W'(RAD_PER_COUNT_Q32);
			end
			S_MRAD: begin
				mul_a = MUL_A_W'(abs_dq_q);
				mul_b = MUL_B_W'(MRAD_PER_RAD);
			end
			S_VR: begin
				mul_a = MUL_A_W'(held_step_q);
				mul_b = MUL_B_W'(VEL_Q8_PER_MRAD);
			end
			S_ACC1: begin
				mul_a = MUL_A_W'(coef_current_q);
				mul_b = MUL_B_W'(vsum_q);
			end
			S_ACC2, S_FILT: begin
				mul_a = MUL_A_W'(coef_feedback_q);
				mul_b = MUL_B_W'(prev_filt_vel_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			flip_threshold_q  <= RST_FLIP_THRESHOLD;
			step_limit_mrad_q <= RST_STEP_LIMIT_MRAD;
			coef_current_q    <= RST_COEF_CURRENT;
			coef_feedback_q   <= RST_COEF_FEEDBACK;
			last_sample_q     <= '0;
			older_sample_q    <= '0;
			held_offset_q     <= '0;
			flip_count_q      <= '0;
			just_flipped_q    <= 1'b0;
			bias_pending_q    <= 1'b1;
			angle_bias_q      <= '0;
			th_prev_q         <= TH_W'(ANGLE_OFFSET_Q16);
			held_step_q       <= '0;
			prev_raw_vel_q    <= '0;
			prev_filt_vel_q   <= '0;
			raw_q             <= '0;
			prod_q            <= '0;
			acc_q             <= '0;
			count_q           <= '0;
			th_now_q          <= '0;
			abs_dq_q          <= '0;
			dq_neg_q          <= 1'b0;
			ang_q             <= '0;
			vraw_q            <= '0;
			vsum_q            <= '0;
			out_valid_q       <= 1'b0;
			position_count_q  <= '0;
			angle_q           <= '0;
			velocity_q        <= '0;
		end else begin
			prod_q <= mul_a * mul_b;

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FLIP_THRESHOLD:  flip_threshold_q  <= cfg_data[9:0];
					REG_STEP_LIMIT_MRAD: step_limit_mrad_q <= cfg_data[9:0];
					REG_COEF_CURRENT:    coef_current_q    <= cfg_data[14:0];
					REG_COEF_FEEDBACK:   coef_feedback_q   <= cfg_data[14:0];
				endcase
			end

			if (out_valid_q && out_ready && state_q != S_FILT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						raw_q          <= raw_pos;
						older_sample_q <= last_sample_q;
						last_sample_q  <= raw_pos;
						just_flipped_q <= wrap_hit;
						if (wrap_hit) begin
							// A rising jump means the reading wrapped downward.
							if (!diff2[SAMPLE_BITS]) begin
								if (flip_count_q != FLIP_MIN) begin
									flip_count_q <= flip_count_q - FLIP_COUNT_BITS'(1);
								end
							end else begin
								if (flip_count_q != FLIP_MAX) begin
									flip_count_q <= flip_count_q + FLIP_COUNT_BITS'(1);
								end
							end
							held_offset_q <= (32'(off1) > 32'(flip_threshold_q)) ? off1 : off2;
						end
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					count_q <= sat_count(cnt_sum);
					state_q <= S_TH;
				end
				S_TH: begin
					state_q <= S_DQ;
				end
				S_DQ: begin
					th_now_q <= th_calc;
					state_q  <= S_MAG;
				end
				S_MAG: begin
					abs_dq_q <= dq[TH_W-1] ? ABS_W'(-dq) : ABS_W'(dq);
					dq_neg_q <= dq[TH_W-1];
					// The first sample fixes angle zero.
					if (bias_pending_q) begin
						angle_bias_q   <= sat_angle(th_now_q);
						bias_pending_q <= 1'b0;
					end
					ang_q   <= sat_angle(ang_diff);
					state_q <= S_MRAD;
				end
				S_MRAD: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (!step_over) begin
						held_step_q <= mrad;
					end
					state_q <= S_VR;
				end
				S_VR: begin
					state_q <= S_SUMV;
				end
				S_SUMV: begin
					vraw_q  <= vraw_calc;
					vsum_q  <= VSUM_W'(vraw_calc) + VSUM_W'(prev_raw_vel_q);
					state_q <= S_ACC1;
				end
				S_ACC1: begin
					state_q <= S_ACC2;
				end
				S_ACC2: begin
					acc_q   <= prod_q;
					state_q <= S_FILT;
				end
				S_FILT: begin
					if (out_free) begin
						prev_raw_vel_q   <= vraw_q;
						prev_filt_vel_q  <= vf_calc;
						th_prev_q        <= th_now_q;
						position_count_q <= count_q;
						angle_q          <= ang_q;
						velocity_q       <= vf_calc;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_sensor_unwrap_velocity_filter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_unwrap_velocity_filter_core: self-checking bench for the unwrap core
// Walks a short table of directed samples and register writes, then feeds
// phases of wrapping ramps, held values and noise under random settings. Every
// result is checked field by field against a typed-in expectation or a
// bit-accurate predictor of the unwrap, angle, step limit and velocity filter arithmetic.
// ----------------------------------------------------------------------------
module tb_sensor_unwrap_velocity_filter_core;
	import suvf_pkg::*;

	localparam int CLK_HALF         = 5;
	localparam int RESET_CYCLES     = 8;
	localparam int RANDOM_SAMPLES   = 1100;
	localparam int WATCHDOG_CYCLES  = 1000;
	localparam int DRAIN_CYCLES     = 20;
	localparam int FLIP_MAX         = (1 << (DEF_FLIP_COUNT_BITS - 1)) - 1;

	typedef logic [DEF_SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic signed [COUNT_W-1:0] count;
		logic signed [ANGLE_W-1:0] ang;
		logic signed [VEL_W-1:0]   vel;
	} reading_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	// The register field is unused on sample rows; value carries the sample there.
	typedef struct packed {
		row_kind_t               kind;
		cfg_reg_t                reg_sel;
		logic [CFG_DATA_W-1:0]   value;
		logic                    typed;
		reading_t                want;
	} plan_row_t;

	localparam plan_row_t PLAN [32] = '{
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd0,     1'b1, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1023,  1'b1, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1023,  1'b1, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd0,     1'b1, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd20,    1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd40,    1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd60,    1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd100,   1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd140,   1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1023,  1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1023,  1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd512,   1'b0, '0},
		'{ROW_WRITE,  REG_STEP_LIMIT_MRAD, 15'd1000,  1'b0, '0},
		'{ROW_WRITE,  REG_COEF_CURRENT,    15'd32767, 1'b0, '0},
		'{ROW_WRITE,  REG_COEF_FEEDBACK,   15'd32767, 1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd0,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1023,  1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd0,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1023,  1'b0, '0},
		'{ROW_WRITE,  REG_FLIP_THRESHOLD,  15'd0,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd2,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd3,     1'b0, '0},
		'{ROW_WRITE,  REG_COEF_CURRENT,    15'd0,     1'b0, '0},
		'{ROW_WRITE,  REG_COEF_FEEDBACK,   15'd0,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd700,   1'b0, '0},
		'{ROW_WRITE,  REG_FLIP_THRESHOLD,  15'd1023,  1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd0,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd1023,  1'b0, '0},
		'{ROW_WRITE,  REG_STEP_LIMIT_MRAD, 15'd0,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd5,     1'b0, '0},
		'{ROW_SAMPLE, REG_FLIP_THRESHOLD,  15'd600,   1'b0, '0}
	};

	localparam cfg_reg_t ALL_REGS [4] = '{REG_FLIP_THRESHOLD, REG_STEP_LIMIT_MRAD,
		REG_COEF_CURRENT, REG_COEF_FEEDBACK};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	sample_t               raw_pos   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [COUNT_W-1:0] position_count;
	logic signed [ANGLE_W-1:0] angle;
	logic signed [VEL_W-1:0]   velocity;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_FLIP_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Typed-in expectation travels with the sample so the monitor sees it at the
	// same edge as the transaction.
	logic     tag_typed = 1'b0;
	reading_t tag_want  = '0;

	reading_t due_readings[$];
	int       mismatches   = 0;
	int       quiet_cycles = 0;
	int       samples_sent = 0;
	int       burst_left   = 0;
	bit       shallow_thr  = 1'b0;

	// Predictor settings and state.
	longint wrap_thr = longint'(RST_FLIP_THRESHOLD);
	longint step_limit = longint'(RST_STEP_LIMIT_MRAD);
	longint w_cur = longint'(RST_COEF_CURRENT), w_fb = longint'(RST_COEF_FEEDBACK);
	sample_t hist_last = '0, hist_older = '0;
	int     flips = 0;
	longint jump_size = 0, count_prev = 0, angle_zero = 0, held_step = 0;
	longint vraw_prev = 0, vf_prev = 0;
	bit     wrapped_last = 1'b0, zero_pending = 1'b1;

	rx_mode_t rx_mode = RX_FREE;
	int rx_left = 0, rx_period = 4, rx_hold = 1, rx_phase = 0;

	sensor_unwrap_velocity_filter_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_pos        (raw_pos),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.position_count (position_count),
		.angle          (angle),
		.velocity       (velocity),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	function automatic longint clamp(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// Absolute angle in Q16 rad for an unwrapped count, rounded half up.
	function automatic longint count_to_angle(longint pos);
		return ANGLE_OFFSET_Q16 - ((pos * RAD_PER_COUNT_Q32 + (longint'(1) << 15)) >>> 16);
	endfunction

	function automatic reading_t unwrap_and_filter(sample_t s);
		longint raw, d1, d2, o1, o2, cnt, th_now, th_prev, dq, dmag, step;
		longint vraw, acc, vf, ang;
		reading_t r;
		raw = longint'(s);
		d1 = raw - longint'(hist_last);
		d2 = raw - longint'(hist_older);
		o1 = (d1 < 0) ? -d1 : d1;
		o2 = (d2 < 0) ? -d2 : d2;
		hist_older = hist_last;
		hist_last = s;

		// A wrap is judged against the sample two ticks back and never twice in a row.
		if (o2 > wrap_thr && !wrapped_last) begin
			if (d2 > 0) begin
				if (flips > -FLIP_MAX - 1)
					flips--;
			end else if (flips < FLIP_MAX) begin
				flips++;
			end
			jump_size = (o1 > wrap_thr) ? o1 : o2;
			wrapped_last = 1'b1;
		end else begin
			wrapped_last = 1'b0;
		end
		cnt = clamp(raw + longint'(flips) * jump_size, COUNT_W);

		th_now = count_to_angle(cnt);
		th_prev = count_to_angle(count_prev);
		count_prev = cnt;
		dq = th_now - th_prev;
		dmag = (((dq < 0) ? -dq : dq) * MRAD_PER_RAD) >>> 16;
		step = (dmag > step_limit) ? held_step : ((dq < 0) ? -dmag : dmag);
		held_step = step;

		if (zero_pending) begin
			angle_zero = clamp(th_now, ANGLE_W);
			zero_pending = 1'b0;
		end
		ang = clamp(th_now - angle_zero, ANGLE_W);

		vraw = clamp(step * VEL_Q8_PER_MRAD, VRAW_W);
		acc = w_cur * (vraw + vraw_prev) + w_fb * vf_prev;
		vf = clamp((acc + (longint'(1) << 14)) >>> 15, VEL_W);
		vraw_prev = vraw;
		vf_prev = vf;

		r.count = cnt[COUNT_W-1:0];
		r.ang = ang[ANGLE_W-1:0];
		r.vel = vf[VEL_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string what, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	// Results are checked before the sample of the same edge is queued.
	always @(posedge clk) begin : monitor
		reading_t got, want, guess;
		if (out_valid && out_ready) begin
			got = '{position_count, angle, velocity};
			if (due_readings.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %0d %0d %0d",
					$time, got.count, got.ang, got.vel);
			end else begin
				want = due_readings.pop_front();
				check_field("position_count", longint'(want.count), longint'(got.count));
				check_field("angle", longint'(want.ang), longint'(got.ang));
				check_field("velocity", longint'(want.vel), longint'(got.vel));
			end
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FLIP_THRESHOLD:  wrap_thr = longint'(cfg_data[9:0]);
				REG_STEP_LIMIT_MRAD: step_limit = longint'(cfg_data[9:0]);
				REG_COEF_CURRENT:    w_cur = longint'(cfg_data);
				REG_COEF_FEEDBACK:   w_fb = longint'(cfg_data);
				default: ;
			endcase
		end
		if (in_valid && in_ready) begin
			guess = unwrap_and_filter(raw_pos);
			due_readings.push_back(tag_typed ? tag_want : guess);
		end
	end

	// The receiver switches between free running, random stalls and a periodic
	// stall pattern.
	always @(posedge clk) begin : rx_stall
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(40, 300);
			rx_period = $urandom_range(4, 24);
			rx_hold = $urandom_range(1, rx_period - 1);
			rx_phase = 0;
		end
		rx_left--;
		rx_phase = (rx_phase + 1) % rx_period;
		case (rx_mode)
			RX_FREE:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
			default:   out_ready <= (rx_phase >= rx_hold);
		endcase
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("tb_sensor_unwrap_velocity_filter_core: FAIL");
			$finish;
		end
	end

	task automatic send_sample(sample_t s, logic typed = 1'b0, reading_t want = '0);
		int gap;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		raw_pos <= s;
		tag_typed <= typed;
		tag_want <= want;
		samples_sent++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (due_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] val);
		if (which == REG_FLIP_THRESHOLD)
			shallow_thr = (val < 64);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	function automatic int unsigned pick_setting(cfg_reg_t which);
		int unsigned top;
		top = (which == REG_FLIP_THRESHOLD) ? 1023 :
			(which == REG_STEP_LIMIT_MRAD) ? 1000 : 32767;
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return top;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	// One stretch of sensor motion: mostly wrapping ramps, some held values and noise.
	task automatic send_pattern();
		int pos, slope, jit, len;
		pos = $urandom_range(0, 1023);
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				repeat ($urandom_range(1, 6))
					send_sample(sample_t'($urandom_range(0, 1023)));
			end
			3, 4: begin
				repeat ($urandom_range(2, 10))
					send_sample(sample_t'(pos));
			end
			default: begin
				slope = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
				if ($urandom_range(0, 1))
					slope = -slope;
				jit = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
				len = $urandom_range(8, 60);
				// With a low threshold even small moves can count as wraps, so long clean ramps
				// drive the flip count into its limits.
				if (shallow_thr) begin
					len = $urandom_range(100, 180);
					jit = 0;
				end
				repeat (len) begin
					send_sample(sample_t'(pos + int'($urandom_range(0, 2 * jit)) - jit));
					pos += slope;
				end
			end
		endcase
	endtask

	initial begin : stimulus
		int target, phase_end;
		bit first_phase;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				wait_for_quiet();
				write_reg(PLAN[i].reg_sel, PLAN[i].value);
			end else begin
				send_sample(PLAN[i].value[DEF_SAMPLE_BITS-1:0], PLAN[i].typed, PLAN[i].want);
			end
		end

		target = samples_sent + RANDOM_SAMPLES;
		first_phase = 1'b1;
		while (samples_sent < target) begin
			wait_for_quiet();
			foreach (ALL_REGS[k]) begin
				if (first_phase && ALL_REGS[k] == REG_FLIP_THRESHOLD)
					write_reg(ALL_REGS[k], CFG_DATA_W'($urandom_range(0, 20)));
				else if ($urandom_range(0, 1))
					write_reg(ALL_REGS[k], CFG_DATA_W'(pick_setting(ALL_REGS[k])));
			end
			first_phase = 1'b0;
			phase_end = samples_sent + $urandom_range(60, 160);
			while (samples_sent < phase_end)
				send_pattern();
		end

		wait_for_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_sensor_unwrap_velocity_filter_core: PASS");
		else
			$display("tb_sensor_unwrap_velocity_filter_core: FAIL");
		$finish;
	end

endmodule
